/* sv/rcc_pkg.sv */
`timescale 1ns / 1ps

package rcc_pkg;

  localparam int ROBOT_XY_W = 17;
  localparam int OBS_XY_W   = 13;
  localparam int BOX_SIZE_W = 10;
  localparam int CRAD_W     = 14;
  localparam int IMG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [IMG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic signed [ROBOT_XY_W-1:0] robot_x;
    logic signed [ROBOT_XY_W-1:0] robot_y;
    logic                         has_obstacle;
    logic                         is_box;
    logic signed [OBS_XY_W-1:0]   obstacle_x;
    logic signed [OBS_XY_W-1:0]   obstacle_y;
    logic [BOX_SIZE_W-1:0]        box_width;
    logic [BOX_SIZE_W-1:0]        box_height;
    logic [CRAD_W-1:0]            circle_radius;
  } item_t;

  // Signed width that holds every position and difference at the box scale.
  function automatic int pos_width(input int frac);
    return ((frac + 15 > 18) ? frac + 15 : 18) + 2;
  endfunction

  // Unsigned width that holds every compare radius.
  function automatic int rad_width(input int frac);
    return (frac + 9 > 15) ? frac + 9 : 15;
  endfunction

endpackage

/* sv/rcc_prep.sv */
`timescale 1ns / 1ps

module rcc_prep #(
  parameter int BODY_RADIUS = 25,
  parameter int FRAC_BITS   = 4
) (
  input  rcc_pkg::item_t                                      item,
  input  logic [rcc_pkg::IMG_W-1:0]                           image_width,
  input  logic [rcc_pkg::IMG_W-1:0]                           image_height,
  output logic                                                bnd_hit,
  output logic [rcc_pkg::rad_width(FRAC_BITS)-1:0]            dist_x,
  output logic [rcc_pkg::rad_width(FRAC_BITS)-1:0]            dist_y,
  output logic [rcc_pkg::rad_width(FRAC_BITS)-1:0]            rad
);
  import rcc_pkg::*;

  localparam int PW = pos_width(FRAC_BITS);
  localparam int RW = rad_width(FRAC_BITS);

  localparam logic signed [PW-1:0] R_FX = PW'(BODY_RADIUS * (2 ** FRAC_BITS));
  localparam logic [RW-1:0] R_FX_RW  = RW'(BODY_RADIUS * (2 ** FRAC_BITS));
  localparam logic [RW-1:0] R_BOX_RW = RW'(BODY_RADIUS * (2 ** (FRAC_BITS + 1)));

  logic signed [PW-1:0] rx, ry, ox, oy, w_fx, h_fx;
  logic signed [PW-1:0] px, py, cx, cy, hw, hh;
  logic signed [PW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [PW-1:0] bdx, bdy, cdx, cdy;

  // Magnitude, saturated at all ones; a saturated value is never below the radius.
  function automatic logic [RW-1:0] sat_abs(input logic signed [PW-1:0] d);
    logic [PW-1:0] m;
    m = d[PW-1] ? PW'(-d) : PW'(d);
    return (|m[PW-1:RW]) ? '1 : m[RW-1:0];
  endfunction

  always_comb begin
    rx   = PW'(item.robot_x);
    ry   = PW'(item.robot_y);
    ox   = PW'(item.obstacle_x);
    oy   = PW'(item.obstacle_y);
    w_fx = PW'(image_width) <<< FRAC_BITS;
    h_fx = PW'(image_height) <<< FRAC_BITS;

    bnd_hit = (rx < R_FX) || (rx + R_FX >= w_fx) ||
              (ry < R_FX) || (ry + R_FX >= h_fx);

    px   = rx <<< 1;
    py   = ry <<< 1;
    cx   = ox <<< (FRAC_BITS + 1);
    cy   = oy <<< (FRAC_BITS + 1);
    hw   = PW'(item.box_width) <<< FRAC_BITS;
    hh   = PW'(item.box_height) <<< FRAC_BITS;
    lo_x = cx - hw;
    hi_x = cx + hw;
    lo_y = cy - hh;
    hi_y = cy + hh;

    if (px > hi_x) begin
      bdx = px - hi_x;
    end else if (px < lo_x) begin
      bdx = px - lo_x;
    end else begin
      bdx = '0;
    end
    if (py > hi_y) begin
      bdy = py - hi_y;
    end else if (py < lo_y) begin
      bdy = py - lo_y;
    end else begin
      bdy = '0;
    end

    cdx = rx - (ox <<< FRAC_BITS);
    cdy = ry - (oy <<< FRAC_BITS);

    if (item.is_box) begin
      dist_x = sat_abs(bdx);
      dist_y = sat_abs(bdy);
      rad    = R_BOX_RW;
    end else begin
      dist_x = sat_abs(cdx);
      dist_y = sat_abs(cdy);
      rad    = RW'(item.circle_radius) + R_FX_RW;
    end
  end

endmodule

/* sv/robot_collision_check.sv */
`timescale 1ns / 1ps
// A result for a query reaches the master side through the input, distance and result
// registers in turn. Throughput: one item per cycle, set by the three-register pipeline
// (input, distance, result); it stalls only while a result waits and another one is due.
// Reset is synchronous: it empties the pipeline and the result register, clears the hit
// accumulator and sets the image size to 640 by 480.

module robot_collision_check #(
  parameter int BODY_RADIUS = 25,
  parameter int FRAC_BITS   = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // robot_x, robot_y, obstacle_x, obstacle_y, box_width, box_height, circle_radius, zeros
  input  logic [rcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // has_obstacle, is_box
  input  logic [rcc_pkg::IN_USER_W-1:0]      s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // collided, zeros
  output logic [rcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  rcc_pkg::cfg_idx_t                  cfg_index,
  input  logic [rcc_pkg::IMG_W-1:0]          cfg_data
);
  import rcc_pkg::*;

  localparam int RW = rad_width(FRAC_BITS);

  logic [IMG_W-1:0] image_width, image_height;

  item_t in_item;
  item_t item1;
  logic  v1, last1;

  logic          v2, last2, bnd2, obs2;
  logic [RW-1:0] dx2, dy2, rad2;

  logic          bnd_c;
  logic [RW-1:0] dx_c, dy_c, rad_c;

  logic [2*RW-1:0] sq_x, sq_y, sq_r;
  logic [2*RW:0]   sq_sum;
  logic            hit2, hit_all;
  logic            hit_so_far;
  logic            out_valid, collided;
  logic            out_free, adv1, adv2, s_in;

  always_comb begin
    in_item.robot_x       = s_axis_tdata[16:0];
    in_item.robot_y       = s_axis_tdata[33:17];
    in_item.obstacle_x    = s_axis_tdata[46:34];
    in_item.obstacle_y    = s_axis_tdata[59:47];
    in_item.box_width     = s_axis_tdata[69:60];
    in_item.box_height    = s_axis_tdata[79:70];
    in_item.circle_radius = s_axis_tdata[93:80];
    in_item.has_obstacle  = s_axis_tuser[0];
    in_item.is_box        = s_axis_tuser[1];
  end

  rcc_prep #(
    .BODY_RADIUS  (BODY_RADIUS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_prep (
    .item         (item1),
    .image_width  (image_width),
    .image_height (image_height),
    .bnd_hit      (bnd_c),
    .dist_x       (dx_c),
    .dist_y       (dy_c),
    .rad          (rad_c)
  );

  always_comb begin
    sq_x    = dx2 * dx2;
    sq_y    = dy2 * dy2;
    sq_r    = rad2 * rad2;
    sq_sum  = {1'b0, sq_x} + {1'b0, sq_y};
    hit2    = bnd2 || (obs2 && (sq_sum < {1'b0, sq_r}));
    hit_all = hit_so_far || hit2;
  end

  assign out_free      = !out_valid || m_axis_tready;
  assign adv2          = v2 && (!last2 || out_free);
  assign adv1          = v1 && (!v2 || adv2);
  assign s_axis_tready = !v1 || adv1;
  assign s_in          = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, collided};
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
      hit_so_far <= 1'b0;
    end else begin
      if (s_in) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end

      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end

      if (adv2 && last2) begin
        out_valid  <= 1'b1;
        hit_so_far <= 1'b0;
      end else begin
        if (m_axis_tready) begin
          out_valid <= 1'b0;
        end
        if (adv2) begin
          hit_so_far <= hit_all;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_in) begin
      item1 <= in_item;
      last1 <= s_axis_tlast;
    end
    if (adv1) begin
      last2 <= last1;
      bnd2  <= bnd_c;
      obs2  <= item1.has_obstacle;
      dx2   <= dx_c;
      dy2   <= dy_c;
      rad2  <= rad_c;
    end
    if (adv2 && last2) begin
      collided <= hit_all;
    end
  end

endmodule
